[rtl/napq_pkg.sv]
package napq_pkg;

    // Fixed field widths of the channels
    localparam int ACTION_W     = 2;
    localparam int KEY_W        = 7;
    localparam int IN_PERIOD_W  = 24;
    localparam int OUT_PERIOD_W = 24;

    // Pitch classes per octave
    localparam int NUM_CLASSES = 12;
    localparam int CLASS_W     = 4;

    // Register port
    localparam int REG_ADDR_W = 3;
    localparam int REG_DATA_W = 32;
    localparam logic [0:0] REG_USE_LOCK  = 1'b0;
    localparam logic [0:0] REG_LOCK_MASK = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2,
        ACT_QUERY    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                   use_lock;
        logic [NUM_CLASSES-1:0] lock_mask;
    } cfg_t;

    // key mod 12 via multiply by 43/512 (exact floor for keys below 128)
    function automatic logic [CLASS_W-1:0] key_class(input logic [KEY_W-1:0] key);
        logic [12:0] prod;
        logic [3:0]  quot;
        logic [6:0]  quot12;
        logic [6:0]  rem;
        prod   = {6'd0, key} * 13'd43;
        quot   = prod[12:9];
        quot12 = 7'({quot, 3'b000}) + 7'({quot, 2'b00});
        rem    = key - quot12;
        return rem[CLASS_W-1:0];
    endfunction

endpackage

[rtl/napq_in_if.sv]
interface napq_in_if;
    logic                                valid;
    logic                                ready;
    logic [napq_pkg::ACTION_W-1:0]       action;
    logic [napq_pkg::KEY_W-1:0]          note_key;
    logic [napq_pkg::IN_PERIOD_W-1:0]    period_value;

    modport source (output valid, action, note_key, period_value, input ready);
    modport sink   (input valid, action, note_key, period_value, output ready);
endinterface

[rtl/napq_out_if.sv]
interface napq_out_if;
    logic                                valid;
    logic                                ready;
    logic [napq_pkg::OUT_PERIOD_W-1:0]   chosen_period;
    logic                                snapped;

    modport source (output valid, chosen_period, snapped, input ready);
    modport sink   (input valid, chosen_period, snapped, output ready);
endinterface

[rtl/napq_ram.sv]
module napq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/napq_cfg.sv]
module napq_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [napq_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [napq_pkg::REG_DATA_W-1:0]     pwdata,
    output logic [napq_pkg::REG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output napq_pkg::cfg_t                      cfg
);
    import napq_pkg::*;

    logic                   use_lock_reg,  use_lock_next;
    logic [NUM_CLASSES-1:0] lock_mask_reg, lock_mask_next;
    logic [0:0]             reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_comb
    begin
        use_lock_next  = use_lock_reg;
        lock_mask_next = lock_mask_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_USE_LOCK:  use_lock_next  = pwdata[0];
                REG_LOCK_MASK: lock_mask_next = pwdata[NUM_CLASSES-1:0];
                default:       use_lock_next  = use_lock_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_USE_LOCK:  prdata = {{(REG_DATA_W-1){1'b0}}, use_lock_reg};
            REG_LOCK_MASK: prdata = {{(REG_DATA_W-NUM_CLASSES){1'b0}}, lock_mask_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_lock_reg  <= 1'b0;
            lock_mask_reg <= '0;
        end
        else
        begin
            use_lock_reg  <= use_lock_next;
            lock_mask_reg <= lock_mask_next;
        end
    end

    assign cfg.use_lock  = use_lock_reg;
    assign cfg.lock_mask = lock_mask_reg;
endmodule

[rtl/nearest_allowed_note_period.sv]
// Pitch quantizer: snaps a measured period to the nearest allowed note period.
// Input channel in_ch carries one item per handshake: action, note_key,
// period_value. Load writes the period table at note_key; note on
// and note off update the pitch-class hold counter (read-modify-
// write of the counter RAM). Query scans the period table one entry per cycle
// through the table RAM read port; the result reaches out_ch once the scan
// pipeline has drained, and in_ch is ready again in that same cycle.
// The scan length (one table entry per cycle) sets query rate when out_ch is free.
// Only queries produce a result item on out_ch: chosen_period and snapped.
// The result sits in an output register; loads and note events are still
// taken while it waits. A query that finishes while the previous result is
// unclaimed holds until out_ch.ready is seen.
// Configuration (use_lock, lock_mask) is written over the APB port at byte
// addresses 0 and 4. The user must write it only while no item is in
// flight; the block does not enforce this. Reset clears the counters,
// config, control state and output; table entries are undefined until loaded.
module nearest_allowed_note_period #(
    parameter int NUM_NOTES   = 128,
    parameter int PERIOD_BITS = 24,
    parameter int COUNT_BITS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    napq_in_if.sink                             in_ch,
    napq_out_if.source                          out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [napq_pkg::REG_ADDR_W-1:0]     paddr,
    input  logic [napq_pkg::REG_DATA_W-1:0]     pwdata,
    output logic [napq_pkg::REG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import napq_pkg::*;

    localparam int IDX_W = $clog2(NUM_NOTES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    cfg_t cfg;

    state_t                  state_reg, state_next;
    action_t                 act_reg, act_next;
    logic [CLASS_W-1:0]      cls_reg, cls_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CLASS_W-1:0]      scls_reg, scls_next;
    logic [PERIOD_BITS-1:0]  period_reg, period_next;
    logic [NUM_CLASSES-1:0]  cnt_valid_reg, cnt_valid_next;
    logic [NUM_CLASSES-1:0]  nz_mask_reg, nz_mask_next;

    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_allow_reg, s1_allow_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic                    s2_allow_reg, s2_allow_next;
    logic [PERIOD_BITS-1:0]  s2_diff_reg, s2_diff_next;
    logic [PERIOD_BITS-1:0]  s2_entry_reg, s2_entry_next;
    logic                    found_reg, found_next;
    logic [PERIOD_BITS-1:0]  best_diff_reg, best_diff_next;
    logic [PERIOD_BITS-1:0]  best_period_reg, best_period_next;

    logic                    out_valid_reg, out_valid_next;
    logic [OUT_PERIOD_W-1:0] out_period_reg, out_period_next;
    logic                    out_snapped_reg, out_snapped_next;

    logic                    in_ready;
    logic                    accept;
    logic                    key_ok;
    logic [PERIOD_BITS-1:0]  period_in;
    logic [CLASS_W-1:0]      key_cls;
    logic [NUM_CLASSES-1:0]  allowed;

    logic                    tab_we;
    logic [PERIOD_BITS-1:0]  tab_rdata;
    logic                    cnt_we;
    logic [COUNT_BITS-1:0]   cnt_rdata;
    logic [COUNT_BITS-1:0]   cnt_cur;
    logic [COUNT_BITS-1:0]   cnt_new;

    napq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Note period table
    napq_ram #(
        .WIDTH (PERIOD_BITS),
        .DEPTH (NUM_NOTES)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (IDX_W'(in_ch.note_key)),
        .wdata (period_in),
        .raddr (idx_reg),
        .rdata (tab_rdata)
    );

    // Pitch-class hold counters
    napq_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_CLASSES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cls_reg),
        .wdata (cnt_new),
        .raddr (key_cls),
        .rdata (cnt_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_ch.valid && in_ready;
    assign key_ok    = (32'(in_ch.note_key) < 32'(NUM_NOTES));
    assign period_in = PERIOD_BITS'(in_ch.period_value);
    assign key_cls   = key_class(in_ch.note_key);
    assign allowed   = cfg.use_lock ? cfg.lock_mask : nz_mask_reg;

    // Counter update; an entry not yet written reads as zero
    always_comb
    begin
        cnt_cur = cnt_valid_reg[cls_reg] ? cnt_rdata : '0;
        if (act_reg == ACT_NOTE_ON)
        begin
            cnt_new = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
        end
        else
        begin
            cnt_new = (cnt_cur == '0) ? cnt_cur : cnt_cur - COUNT_BITS'(1);
        end
    end

    // Control and scan datapath
    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        cls_next         = cls_reg;
        idx_next         = idx_reg;
        scls_next        = scls_reg;
        period_next      = period_reg;
        cnt_valid_next   = cnt_valid_reg;
        nz_mask_next     = nz_mask_reg;
        tab_we           = 1'b0;
        cnt_we           = 1'b0;
        out_period_next  = out_period_reg;
        out_snapped_next = out_snapped_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;

        // stage 1: table read in flight
        s1_valid_next = 1'b0;
        s1_allow_next = s1_allow_reg;

        // stage 2: distance to the measured period
        s2_valid_next = s1_valid_reg;
        s2_allow_next = s1_allow_reg;
        s2_entry_next = tab_rdata;
        s2_diff_next  = (tab_rdata >= period_reg) ? tab_rdata - period_reg
                                                  : period_reg - tab_rdata;

        // stage 3: keep the best so far, lowest index wins ties
        found_next       = found_reg;
        best_diff_next   = best_diff_reg;
        best_period_next = best_period_reg;
        if (s2_valid_reg && s2_allow_reg && (!found_reg || s2_diff_reg < best_diff_reg))
        begin
            found_next       = 1'b1;
            best_diff_next   = s2_diff_reg;
            best_period_next = s2_entry_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(in_ch.action))
                        ACT_LOAD:
                        begin
                            tab_we = key_ok;
                        end
                        ACT_QUERY:
                        begin
                            period_next = period_in;
                            idx_next    = '0;
                            scls_next   = '0;
                            found_next  = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        default:
                        begin
                            act_next   = action_t'(in_ch.action);
                            cls_next   = key_cls;
                            state_next = ST_COUNT;
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                cnt_we                  = 1'b1;
                cnt_valid_next[cls_reg] = 1'b1;
                nz_mask_next[cls_reg]   = (cnt_new != '0);
                state_next              = ST_IDLE;
            end
            ST_SCAN:
            begin
                s1_valid_next = 1'b1;
                s1_allow_next = allowed[scls_reg];
                idx_next      = idx_reg + IDX_W'(1);
                scls_next     = (scls_reg == CLASS_W'(NUM_CLASSES - 1)) ? '0
                                                                        : scls_reg + CLASS_W'(1);
                if (idx_reg == IDX_W'(NUM_NOTES - 1))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!s1_valid_reg && !s2_valid_reg && (!out_valid_reg || out_ch.ready))
                begin
                    out_valid_next   = 1'b1;
                    out_period_next  = OUT_PERIOD_W'(found_reg ? best_period_reg : period_reg);
                    out_snapped_next = found_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_valid_reg <= '0;
            nz_mask_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_valid_reg <= cnt_valid_next;
            nz_mask_reg   <= nz_mask_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        cls_reg         <= cls_next;
        idx_reg         <= idx_next;
        scls_reg        <= scls_next;
        period_reg      <= period_next;
        s1_allow_reg    <= s1_allow_next;
        s2_allow_reg    <= s2_allow_next;
        s2_diff_reg     <= s2_diff_next;
        s2_entry_reg    <= s2_entry_next;
        best_diff_reg   <= best_diff_next;
        best_period_reg <= best_period_next;
        out_period_reg  <= out_period_next;
        out_snapped_reg <= out_snapped_next;
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.chosen_period = out_period_reg;
    assign out_ch.snapped       = out_snapped_reg;
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import napq_pkg::*;

    localparam int NUM_NOTES        = 128;
    localparam int COUNT_FULL       = 255;
    localparam int NUM_PHASES       = 7;
    localparam int RANDOM_PER_PHASE = 105;
    localparam int SETTLE_CYCLES    = NUM_NOTES + 72;
    localparam int CYCLE_LIMIT      = 1200000;
    localparam int MAX_REPORTS      = 10;

    localparam logic [REG_ADDR_W-1:0]  ADDR_USE_LOCK  = {REG_USE_LOCK, 2'b00};
    localparam logic [REG_ADDR_W-1:0]  ADDR_LOCK_MASK = {REG_LOCK_MASK, 2'b00};
    localparam logic [IN_PERIOD_W-1:0] PERIOD_MAX     = '1;

    typedef struct packed {
        action_t                act;
        logic [KEY_W-1:0]       key;
        logic [IN_PERIOD_W-1:0] period;
    } note_event_t;

    typedef struct packed {
        logic [OUT_PERIOD_W-1:0] period;
        logic                    snapped;
    } pitch_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Channel drive
    logic                   in_valid  = 1'b0;
    logic [ACTION_W-1:0]    in_action = '0;
    logic [KEY_W-1:0]       in_key    = '0;
    logic [IN_PERIOD_W-1:0] in_period = '0;
    logic                   res_ready = 1'b0;

    // Register port
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [REG_ADDR_W-1:0] paddr   = '0;
    logic [REG_DATA_W-1:0] pwdata  = '0;
    logic [REG_DATA_W-1:0] prdata;
    logic                  pready;

    napq_in_if  in_ch ();
    napq_out_if out_ch ();

    assign in_ch.valid        = in_valid;
    assign in_ch.action       = in_action;
    assign in_ch.note_key     = in_key;
    assign in_ch.period_value = in_period;
    assign out_ch.ready       = res_ready;

    nearest_allowed_note_period i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Quantizer state as the block should hold it
    logic [IN_PERIOD_W-1:0] note_periods [NUM_NOTES];
    logic [7:0]             held_count [NUM_CLASSES] = '{default: '0};
    logic                   lock_on   = 1'b0;
    logic [NUM_CLASSES-1:0] lock_mask = '0;

    // Table contents as they will be once every queued item is applied
    logic [IN_PERIOD_W-1:0] staged_periods [NUM_NOTES] = '{default: '0};

    note_event_t queued_events [$];
    pitch_t      expected_pitches [$];

    bit in_taken      = 1'b0;
    bit out_taken     = 1'b0;
    int in_gap_left   = 0;
    int in_gap_max    = 9;
    int stall_left    = 0;
    int out_stall_max = 9;

    int mismatch_count = 0;
    int results_seen   = 0;
    int snapped_seen   = 0;
    int event_tally [4] = '{default: 0};
    int cycle_count    = 0;

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    function automatic bit class_open(input int cls);
        if (lock_on)
            return lock_mask[cls];
        return held_count[cls] != 8'd0;
    endfunction

    // Closest allowed table period, lowest index on a tie
    function automatic pitch_t nearest_period(input logic [IN_PERIOD_W-1:0] measured);
        pitch_t                 pick;
        logic [IN_PERIOD_W-1:0] delta;
        logic [IN_PERIOD_W-1:0] best_dist;
        int                     n;
        pick.period  = measured;
        pick.snapped = 1'b0;
        best_dist    = '0;
        for (n = 0; n < NUM_NOTES; n++)
        begin
            if (class_open(n % NUM_CLASSES))
            begin
                delta = (note_periods[n] > measured) ? note_periods[n] - measured
                                                     : measured - note_periods[n];
                if (!pick.snapped || delta < best_dist)
                begin
                    pick.snapped = 1'b1;
                    pick.period  = note_periods[n];
                    best_dist    = delta;
                end
            end
        end
        return pick;
    endfunction

    function automatic void apply_event(input note_event_t ev);
        int cls;
        cls = int'(ev.key) % NUM_CLASSES;
        event_tally[ev.act]++;
        case (ev.act)
            ACT_LOAD:     note_periods[ev.key] = ev.period;
            ACT_NOTE_ON:  if (held_count[cls] != 8'(COUNT_FULL)) held_count[cls]++;
            ACT_NOTE_OFF: if (held_count[cls] != 8'd0) held_count[cls]--;
            default:      expected_pitches.push_back(nearest_period(ev.period));
        endcase
    endfunction

    function automatic void queue_event(input action_t act, input int key,
                                        input logic [IN_PERIOD_W-1:0] period);
        note_event_t ev;
        ev.act    = act;
        ev.key    = KEY_W'(key);
        ev.period = period;
        if (act == ACT_LOAD)
            staged_periods[ev.key] = period;
        queued_events.push_back(ev);
    endfunction

    // Random item; periods are random or aim near table entries, at midpoints of same-class pairs and at extremes
    function automatic void queue_random_event();
        int                     pick;
        int                     a;
        int                     b;
        logic [IN_PERIOD_W:0]   sum;
        logic [IN_PERIOD_W-1:0] p;
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, NUM_NOTES - 1);
        case ($urandom_range(0, 3))
            0: p = IN_PERIOD_W'($urandom());
            1:
            begin
                b = a % NUM_CLASSES + NUM_CLASSES *
                    $urandom_range(0, (NUM_NOTES - 1 - a % NUM_CLASSES) / NUM_CLASSES);
                sum = {1'b0, staged_periods[a]} + {1'b0, staged_periods[b]};
                p   = sum[IN_PERIOD_W:1];
            end
            2: p = staged_periods[$urandom_range(0, NUM_NOTES - 1)]
                   + IN_PERIOD_W'($urandom_range(0, 2)) - IN_PERIOD_W'(1);
            default: p = $urandom_range(0, 1) ? PERIOD_MAX : '0;
        endcase
        if (pick < 25)
            queue_event(ACT_LOAD, a, p);
        else if (pick < 47)
            queue_event(ACT_NOTE_ON, a, IN_PERIOD_W'($urandom()));
        else if (pick < 65)
            queue_event(ACT_NOTE_OFF, a, IN_PERIOD_W'($urandom()));
        else
            queue_event(ACT_QUERY, a, p);
    endfunction

    // Wait for all items taken and all results back, then let a scan finish
    task automatic drain();
        while (queued_events.size() != 0 || in_valid || expected_pitches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [REG_ADDR_W-1:0] addr,
                             input logic [REG_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_USE_LOCK)
            lock_on = data[0];
        else
            lock_mask = data[NUM_CLASSES-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(input logic [REG_ADDR_W-1:0] addr,
                             input logic [REG_DATA_W-1:0] want);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch($sformatf("register 0x%0h read: expected 0x%0h, got 0x%0h",
                                      addr, want, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Item driver: one item per handshake, random gap after each
    always @(negedge clk or negedge rst_n)
    begin : item_driver
        note_event_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            in_gap_left <= 0;
        end
        else if (in_valid && !in_taken)
        begin
            // hold until taken
        end
        else if (in_gap_left != 0)
        begin
            in_valid    <= 1'b0;
            in_gap_left <= in_gap_left - 1;
        end
        else if (queued_events.size() != 0)
        begin
            nxt = queued_events.pop_front();
            in_valid    <= 1'b1;
            in_action   <= nxt.act;
            in_key      <= nxt.key;
            in_period   <= nxt.period;
            in_gap_left <= $urandom_range(0, in_gap_max);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Result ready: random stall after each result taken
    always @(negedge clk or negedge rst_n)
    begin : result_throttle
        int stall;
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_taken)
        begin
            stall = $urandom_range(0, out_stall_max);
            stall_left <= stall;
            res_ready  <= (stall == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_ready  <= (stall_left == 1);
        end
        else
        begin
            res_ready <= 1'b1;
        end
    end

    // Handshake monitor: predict on items taken, check results taken
    always @(posedge clk)
    begin : handshake_monitor
        note_event_t ev;
        pitch_t      want;
        in_taken  <= rst_n && in_valid && in_ch.ready;
        out_taken <= rst_n && out_ch.valid && res_ready;
        if (rst_n && in_valid && in_ch.ready)
        begin
            ev.act    = action_t'(in_action);
            ev.key    = in_key;
            ev.period = in_period;
            apply_event(ev);
        end
        if (rst_n && out_ch.valid && res_ready)
        begin
            results_seen++;
            if (expected_pitches.size() == 0)
            begin
                report_mismatch($sformatf("result with no query pending: 0x%06h snapped %0b",
                                          out_ch.chosen_period, out_ch.snapped));
            end
            else
            begin
                want = expected_pitches.pop_front();
                if (want.snapped)
                    snapped_seen++;
                if (out_ch.chosen_period !== want.period || out_ch.snapped !== want.snapped)
                    report_mismatch($sformatf(
                        "query result: expected 0x%06h snapped %0b, got 0x%06h snapped %0b",
                        want.period, want.snapped, out_ch.chosen_period, out_ch.snapped));
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[nearest_allowed_note_period] ERROR");
        $finish;
    end

    // Stimulus: one register setting per phase, directed items in the first
    initial
    begin : stimulus
        int                     ph;
        int                     n;
        logic                   lock;
        logic [NUM_CLASSES-1:0] mask;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    lock = 1'b0; mask = '0; in_gap_max = 9; out_stall_max = 9;
                end
                1:
                begin
                    lock = 1'b1; mask = '1; in_gap_max = 0; out_stall_max = 9;
                end
                2:
                begin
                    lock = 1'b1; mask = '0; in_gap_max = 9; out_stall_max = 0;
                end
                3:
                begin
                    lock = 1'b1; mask = NUM_CLASSES'($urandom());
                    in_gap_max = 0; out_stall_max = 0;
                end
                4:
                begin
                    lock = 1'b0; mask = NUM_CLASSES'($urandom());
                    in_gap_max = 9; out_stall_max = 9;
                end
                5:
                begin
                    lock = 1'b1; mask = NUM_CLASSES'(1) << $urandom_range(0, NUM_CLASSES - 1);
                    in_gap_max = 9; out_stall_max = 0;
                end
                default:
                begin
                    lock = 1'b0; mask = '1; in_gap_max = 0; out_stall_max = 9;
                end
            endcase
            reg_write(ADDR_USE_LOCK, REG_DATA_W'(lock));
            reg_write(ADDR_LOCK_MASK, REG_DATA_W'(mask));
            reg_check(ADDR_USE_LOCK, REG_DATA_W'(lock));
            reg_check(ADDR_LOCK_MASK, REG_DATA_W'(mask));

            if (ph == 0)
            begin
                // nothing allowed yet: queries pass through, empty counter stays empty
                queue_event(ACT_QUERY, 0, '0);
                queue_event(ACT_QUERY, 127, PERIOD_MAX);
                queue_event(ACT_NOTE_OFF, 3, '0);

                // fill the table; keys 0 and 12 straddle 0x800 for the tie case
                for (n = 0; n < NUM_NOTES; n++)
                    queue_event(ACT_LOAD, n, IN_PERIOD_W'(24'h010000 + n * 256));
                queue_event(ACT_LOAD, 0, 24'h000400);
                queue_event(ACT_LOAD, 12, 24'h000C00);
                queue_event(ACT_LOAD, 127, PERIOD_MAX);

                queue_event(ACT_NOTE_ON, 60, '0);
                queue_event(ACT_QUERY, 0, 24'h000800);
                queue_event(ACT_QUERY, 0, '0);
                queue_event(ACT_QUERY, 0, PERIOD_MAX);
                queue_event(ACT_NOTE_ON, 127, '0);
                queue_event(ACT_QUERY, 0, PERIOD_MAX);
                queue_event(ACT_QUERY, 0, 24'h017E00);
                queue_event(ACT_NOTE_OFF, 48, '0);
                queue_event(ACT_QUERY, 0, 24'h000800);
                queue_event(ACT_NOTE_OFF, 127, '0);
                queue_event(ACT_QUERY, 0, 24'h123456);
                queue_event(ACT_NOTE_OFF, 127, '0);
                queue_event(ACT_LOAD, 127, '0);

                // counter saturation: two extra note-ons, then count down to one and zero
                repeat (COUNT_FULL + 2) queue_event(ACT_NOTE_ON, 5, IN_PERIOD_W'($urandom()));
                queue_event(ACT_QUERY, 0, 24'h014500);
                repeat (COUNT_FULL - 1) queue_event(ACT_NOTE_OFF, 17, IN_PERIOD_W'($urandom()));
                queue_event(ACT_QUERY, 0, 24'h014500);
                queue_event(ACT_NOTE_OFF, 5, '0);
                queue_event(ACT_QUERY, 0, 24'h014500);
            end

            repeat (RANDOM_PER_PHASE) queue_random_event();
        end
        drain();

        $display("Checked %0d quantizer results (%0d snapped, %0d passed through) after %0d loads",
                 results_seen, snapped_seen, results_seen - snapped_seen, event_tally[ACT_LOAD]);
        $display("and %0d note events, over %0d register settings with and without throttling.",
                 event_tally[ACT_NOTE_ON] + event_tally[ACT_NOTE_OFF], NUM_PHASES);
        if (mismatch_count == 0)
            $display("[nearest_allowed_note_period] OK");
        else
            $display("[nearest_allowed_note_period] ERROR");
        $finish;
    end

endmodule

[nearest_allowed_note_period.f]
rtl/napq_pkg.sv
rtl/napq_in_if.sv
rtl/napq_out_if.sv
rtl/napq_ram.sv
rtl/napq_cfg.sv
rtl/nearest_allowed_note_period.sv
bench/tb_top.sv
